// ===== rtl/ring_buffer_placement_select_unit_assert.svh =====
// Assertion macros for the ring buffer placement selector.
// Used by the top level; expects a clk and rst signal in scope.
`ifndef RING_BUFFER_PLACEMENT_SELECT_UNIT_ASSERT_SVH
`define RING_BUFFER_PLACEMENT_SELECT_UNIT_ASSERT_SVH

// same-cycle implication
`define RBPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbps_pkg.sv =====
// Types and codes shared by the ring buffer placement selector modules.
// No dependencies.
package rbps_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFERS_USED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_THRESHOLD = 3'd3;

  localparam logic [15:0] BUFFER_LENGTH_RST = 16'd65535;
  localparam logic [15:0] MAX_BLOCKS_RST    = 16'd65535;
  localparam logic [6:0]  BUFFERS_USED_RST  = 7'd1;
  localparam logic [15:0] BIG_THRESHOLD_RST = 16'd73;

  typedef struct packed {
    logic        command;
    logic [5:0]  entry_index;
    logic [15:0] start_pointer;
    logic [15:0] end_pointer;
    logic [15:0] block_total;
    logic [15:0] place_size;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [5:0] chosen_buffer;
  } out_item_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [15:0] start_ptr;
    logic [15:0] end_ptr;
    logic [15:0] blocks;
  } entry_t;

  typedef struct packed {
    logic clear;  // start of any accepted command (write or place)
    logic eval;   // memory read data is valid this cycle
    logic big;    // most-space policy
  } scan_ctrl_t;

endpackage

// ===== rtl/ring_buffer_placement_select_unit.sv =====
// Ring buffer placement selector, top level: config registers, scan sequencer,
// table memory and result register. Depends on rbps_pkg, rbps_ram, rbps_scan.
//
// A write command loads one table entry and gives no result. A place command
// scans n = min(buffers_in_use, MAX_BUFFERS) entries: the table memory has one
// read port, so the scan reads one entry per cycle; then a drain state waits
// for the registered read data and a finish state loads the result register.
// With buffers_in_use = 0 nothing is read; the result is not found. Input is
// stalled while a place request is in flight; a finished result waits in the
// output register while the next transaction is taken. The table is not
// cleared at reset: scanning an entry never written gives an arbitrary choice.
module ring_buffer_placement_select_unit #(
  parameter int MAX_BUFFERS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rbps_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rbps_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [rbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_data
);

  `include "ring_buffer_placement_select_unit_assert.svh"

  localparam int IDX_W  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
  localparam int NW     = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [15:0] buffer_length;
  logic [15:0] max_blocks;
  logic [6:0]  buffers_used;
  logic [15:0] big_threshold;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] rd_tag;
  logic             rd_vld;
  logic [15:0]      place_size;
  logic             big;

  logic             in_accept;
  logic             out_free;
  logic             ram_we;
  logic             last_read;
  logic [NW-1:0]    n_eff;
  logic             scan_found;
  logic [IDX_W-1:0] scan_best;

  rbps_pkg::entry_t     wr_entry;
  rbps_pkg::entry_t     rd_entry;
  rbps_pkg::scan_ctrl_t ctrl;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= rbps_pkg::BUFFER_LENGTH_RST;
      max_blocks    <= rbps_pkg::MAX_BLOCKS_RST;
      buffers_used  <= rbps_pkg::BUFFERS_USED_RST;
      big_threshold <= rbps_pkg::BIG_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        rbps_pkg::REG_BUFFER_LENGTH: buffer_length <= cfg_data;
        rbps_pkg::REG_MAX_BLOCKS:    max_blocks    <= cfg_data;
        rbps_pkg::REG_BUFFERS_USED:  buffers_used  <= cfg_data[6:0];
        rbps_pkg::REG_BIG_THRESHOLD: big_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (32'(buffers_used) > 32'(MAX_BUFFERS)) begin
      n_eff = NW'(MAX_BUFFERS);
    end else begin
      n_eff = NW'(buffers_used);
    end
  end

  assign last_read = (NW'(rd_idx) == (n_eff - NW'(1)));

  // writes only while idle, so a scan never sees an entry change under it
  assign ram_we = in_accept && (in_data.command == rbps_pkg::CMD_WRITE)
                  && (32'(in_data.entry_index) < 32'(MAX_BUFFERS));

  always_comb begin
    wr_entry.start_ptr = in_data.start_pointer;
    wr_entry.end_ptr   = in_data.end_pointer;
    wr_entry.blocks    = in_data.block_total;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && (in_data.command == rbps_pkg::CMD_PLACE)) begin
          state_next = (n_eff == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_read) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= rd_idx;
    if (in_accept) begin
      rd_idx     <= '0;
      place_size <= in_data.place_size;
      big        <= (in_data.place_size >= big_threshold);
    end else if (state == ST_SCAN && !last_read) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  rbps_ram #(
    .WIDTH ($bits(rbps_pkg::entry_t)),
    .DEPTH (MAX_BUFFERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_data.entry_index)),
    .wdata (wr_entry),
    .re    (state == ST_SCAN),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  always_comb begin
    ctrl.clear = in_accept;
    ctrl.eval  = rd_vld;
    ctrl.big   = big;
  end

  rbps_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .tag           (rd_tag),
    .entry         (rd_entry),
    .buffer_length (buffer_length),
    .max_blocks    (max_blocks),
    .place_size    (place_size),
    .found         (scan_found),
    .best          (scan_best)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_data.found         <= scan_found;
      out_data.chosen_buffer <= scan_found ? 6'(scan_best) : 6'd0;
    end
  end

  `RBPS_ASSERT_NOW(a_no_write_in_scan, ram_we, state == ST_IDLE, "table write during scan")
  `RBPS_ASSERT_NOW(a_read_in_scan, rd_vld, (state == ST_SCAN) || (state == ST_DRAIN),
                   "read data outside scan")
  `RBPS_ASSERT_NEXT(a_result_loaded, (state == ST_FINISH) && out_free, out_valid,
                    "finished place request produced no result")
  `RBPS_ASSERT_NEXT(a_place_starts,
                    in_accept && (in_data.command == rbps_pkg::CMD_PLACE),
                    (state == ST_SCAN) || (state == ST_FINISH),
                    "place request did not start a scan")

endmodule

// ===== rtl/rbps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rbps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rbps_scan.sv =====
// Per-entry evaluation and running best-choice registers for a place scan.
// Depends on rbps_pkg.
module rbps_scan #(
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  rbps_pkg::scan_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    tag,
  input  rbps_pkg::entry_t    entry,
  input  logic [15:0]         buffer_length,
  input  logic [15:0]         max_blocks,
  input  logic [15:0]         place_size,
  output logic                found,
  output logic [IDX_W-1:0]    best
);

  logic signed [16:0] most;
  logic [15:0]        fewest;
  logic signed [16:0] fs;
  logic [15:0]        diff;
  logic               eligible;
  logic               take;

  // free space; wrapped case may go negative
  always_comb begin
    diff = entry.end_ptr - entry.start_ptr;
    if (entry.start_ptr >= entry.end_ptr) begin
      fs = $signed({1'b0, entry.start_ptr - entry.end_ptr});
    end else begin
      fs = $signed({1'b0, buffer_length}) - $signed({1'b0, diff});
    end
    eligible = (fs >= $signed({1'b0, place_size})) && (entry.blocks < max_blocks);
    if (ctrl.big) begin
      take = eligible && (fs > most);
    end else begin
      take = eligible && (!found || (entry.blocks < fewest));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (ctrl.eval && take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      most   <= '0;
      fewest <= '0;
      best   <= '0;
    end else if (ctrl.eval && take) begin
      most   <= fs;
      fewest <= entry.blocks;
      best   <= tag;
    end
  end

endmodule
